### rtl/bwc_pkg.sv
// Shared types and constants of the beat window capture block.
`default_nettype none

package bwc_pkg;

	localparam int WORD_WIDTH  = 32;
	localparam int LANE_COUNT  = 4;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_PEAK = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OVERRUN = 2'd1;
	localparam logic [1:0] STATUS_REFUSED = 2'd2;

	typedef struct packed {
		logic                          cmd;
		logic [WORD_WIDTH-1:0]         push_index;
		logic signed [WORD_WIDTH-1:0]  push_value;
		logic [WORD_WIDTH-1:0]         peak_index;
	} in_item_t;

	typedef struct packed {
		logic [WORD_WIDTH-1:0]         beat_peak;
		logic [5:0]                    word_number;
		logic signed [WORD_WIDTH-1:0]  sample_a;
		logic signed [WORD_WIDTH-1:0]  sample_b;
		logic signed [WORD_WIDTH-1:0]  sample_c;
		logic signed [WORD_WIDTH-1:0]  sample_d;
		logic [1:0]                    status;
		logic                          last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MOD,
		ST_RUN,
		ST_DONE,
		ST_REFUSE
	} state_t;

endpackage

`default_nettype wire

### rtl/bwc_if.sv
// Valid/ready channel interfaces for the input beats and result beats.
`default_nettype none

interface bwc_in_if import bwc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bwc_out_if import bwc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/bwc_rem.sv
// Remainder of a 33-bit value by the ring depth, which is a power of two.
`default_nettype none

module bwc_rem import bwc_pkg::*; #(
	parameter int RING_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [32:0]                   dividend,
	output logic                          done,
	output logic [$clog2(RING_DEPTH)-1:0] rem
);

	localparam int AW = $clog2(RING_DEPTH);

	logic          done_q;
	logic [AW-1:0] rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// keep the low bits: the depth is a power of two
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[AW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

### rtl/beat_window_capture.sv
// Ring buffer of samples with pre-trigger window capture around a peak.
// A push or a request that emits nothing leaves the block ready for the next item; a
// refusal beat goes out through the refuse state. An emitting item passes the PREP and
// MOD set-up states, then is read word by word from the single ring read port, with a
// pause after each word; no input is taken until the last word has left the read path.
// Result stalls hold the read-out. Reset clears control; unwritten ring slots read as zero.
`default_nettype none

module beat_window_capture import bwc_pkg::*; #(
	parameter int RING_DEPTH       = 1024,
	parameter int PRE_SAMPLES      = 72,
	parameter int POST_SAMPLES     = 71,
	parameter int BEAT_LENGTH      = 144,
	parameter int SAMPLES_PER_WORD = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	bwc_in_if.sink    item,
	bwc_out_if.source result
);

	localparam int AW        = $clog2(RING_DEPTH);
	localparam int NUM_WORDS = (BEAT_LENGTH + SAMPLES_PER_WORD - 1) / SAMPLES_PER_WORD;
	localparam int SW        = (SAMPLES_PER_WORD > 1) ? $clog2(SAMPLES_PER_WORD) : 1;
	localparam int PW        = $clog2(NUM_WORDS * SAMPLES_PER_WORD);
	localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	// ring storage and write-side state
	logic [WORD_WIDTH-1:0] ring_mem [RING_DEPTH];
	logic [AW-1:0]         ws_q;          // next slot to write
	logic                  wrapped_q;     // every slot has been written once
	logic [WORD_WIDTH-1:0] newest_q;
	logic                  pending_q;
	logic [WORD_WIDTH-1:0] pending_peak_q;

	// emission control
	state_t                state_q, state_d;
	logic [WORD_WIDTH-1:0] peak_q;        // beat being emitted or refused
	logic                  overrun_q;
	logic [AW-1:0]         addr_q;
	logic [SW-1:0]         slot_q;
	logic [PW-1:0]         pos_q;
	logic [WW-1:0]         word_q;

	// read stage
	logic                  v_s1;
	logic [WORD_WIDTH-1:0] rdata_s1;
	logic [1:0]            lane_s1;
	logic                  lane_ok_s1;
	logic                  keep_s1;
	logic                  end_s1;
	logic                  last_s1;
	logic [5:0]            word_s1;

	// word assembly stage
	logic                         asm_full_s2;
	logic signed [WORD_WIDTH-1:0] asm_lane_s2 [LANE_COUNT];
	logic [5:0]                   asm_word_s2;
	logic                         asm_last_s2;

	// result register
	logic                         out_valid_q;
	logic [WORD_WIDTH-1:0]        out_peak_q;
	logic [5:0]                   out_word_q;
	logic signed [WORD_WIDTH-1:0] out_lane_q [LANE_COUNT];
	logic [1:0]                   out_status_q;
	logic                         out_last_q;

	// combinational control
	logic          accept;
	logic          is_push;
	logic          peak_ok;
	logic          push_emit;
	logic          peak_emit;
	logic          peak_refuse;
	logic          peak_arm;
	logic          issue;
	logic          xfer;
	logic          refuse_load;
	logic          rem_start;
	logic          rem_done;
	logic [AW-1:0] rem_val;
	logic [32:0]   back;
	logic [AW:0]   start_sum;
	logic [AW:0]   start_wrap;
	logic [AW-1:0] start_addr;
	logic          slot_end;
	logic          word_last;
	logic [SW+2:0] slot_ext;
	logic [WW+5:0] word_ext;

	assign accept  = item.valid && item.ready;
	assign is_push = (item.data.cmd == CMD_PUSH);
	assign peak_ok = (item.data.peak_index >= WORD_WIDTH'(PRE_SAMPLES));

	// a push completes the pending window once its index passes the window end
	assign push_emit = is_push && pending_q &&
		({1'b0, item.data.push_index} > ({1'b0, pending_peak_q} + 33'(POST_SAMPLES)));
	assign peak_refuse = !is_push && peak_ok && pending_q;
	assign peak_emit   = !is_push && peak_ok && !pending_q &&
		({1'b0, newest_q} > ({1'b0, item.data.peak_index} + 33'(POST_SAMPLES)));
	assign peak_arm    = !is_push && peak_ok && !pending_q && !peak_emit;

	// distance from the window's first sample back to the newest one, inclusive
	assign back = {1'b0, newest_q} - ({1'b0, peak_q} - 33'(PRE_SAMPLES)) + 33'd1;

	bwc_rem #(
		.RING_DEPTH (RING_DEPTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (back),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// window start slot: the write slot stepped back by the distance, modulo depth
	always_comb begin
		start_sum  = {1'b0, ws_q} + ((AW+1)'(RING_DEPTH) - {1'b0, rem_val});
		start_wrap = start_sum - (AW+1)'(RING_DEPTH);
		if (start_sum >= (AW+1)'(RING_DEPTH)) begin
			start_addr = start_wrap[AW-1:0];
		end else begin
			start_addr = start_sum[AW-1:0];
		end
	end

	// hand the assembled word over when the result register frees up
	assign xfer        = asm_full_s2 && (!out_valid_q || result.ready);
	assign slot_end    = (slot_q == SW'(SAMPLES_PER_WORD - 1));
	assign word_last   = (word_q == WW'(NUM_WORDS - 1));
	assign slot_ext    = {3'b000, slot_q};
	assign word_ext    = {6'd0, word_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d     = state_q;
		item.ready  = 1'b0;
		rem_start   = 1'b0;
		issue       = 1'b0;
		refuse_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					if (push_emit || peak_emit) begin
						state_d = ST_PREP;
					end else if (peak_refuse) begin
						state_d = ST_REFUSE;
					end
				end
			end
			ST_PREP: begin
				rem_start = 1'b1;
				state_d   = ST_MOD;
			end
			ST_MOD: begin
				if (rem_done) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				// hold reads while a finished word is still being assembled
				issue = (!asm_full_s2 || xfer) && !(v_s1 && end_s1);
				if (issue && slot_end && word_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!v_s1 && (!asm_full_s2 || xfer)) begin
					state_d = ST_IDLE;
				end
			end
			ST_REFUSE: begin
				refuse_load = !out_valid_q || result.ready;
				if (refuse_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// write side and pending request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q           <= '0;
			wrapped_q      <= 1'b0;
			newest_q       <= '0;
			pending_q      <= 1'b0;
			pending_peak_q <= '0;
		end else if (accept) begin
			if (is_push) begin
				newest_q <= item.data.push_index;
				if (ws_q == AW'(RING_DEPTH - 1)) begin
					ws_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					ws_q <= ws_q + AW'(1);
				end
				if (push_emit) begin
					pending_q <= 1'b0;
				end
			end else if (peak_arm) begin
				pending_q      <= 1'b1;
				pending_peak_q <= item.data.peak_index;
			end
		end
	end

	// ring memory: one write port for pushes, one registered read for emission
	always_ff @(posedge clk) begin
		if (accept && is_push) begin
			ring_mem[ws_q] <= item.data.push_value;
		end
		if (issue) begin
			rdata_s1 <= ring_mem[addr_q];
		end
	end

	// latch the beat's peak on acceptance, and its overrun flag before the walk
	always_ff @(posedge clk) begin
		if (accept) begin
			if (push_emit) begin
				peak_q <= pending_peak_q;
			end else begin
				peak_q <= item.data.peak_index;
			end
		end
		if (state_q == ST_PREP) begin
			overrun_q <= (back > 33'(RING_DEPTH));
		end
	end

	// walk counters: slot within word, position within beat, word, ring address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			slot_q <= '0;
			pos_q  <= '0;
			word_q <= '0;
		end else if (state_q == ST_MOD && rem_done) begin
			addr_q <= start_addr;
			slot_q <= '0;
			pos_q  <= '0;
			word_q <= '0;
		end else if (issue) begin
			if (addr_q == AW'(RING_DEPTH - 1)) begin
				addr_q <= '0;
			end else begin
				addr_q <= addr_q + AW'(1);
			end
			pos_q <= pos_q + PW'(1);
			if (slot_end) begin
				slot_q <= '0;
				word_q <= word_q + WW'(1);
			end else begin
				slot_q <= slot_q + SW'(1);
			end
		end
	end

	// read stage tags travel with the returning data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			lane_s1    <= slot_ext[1:0];
			lane_ok_s1 <= (slot_ext < (SW+3)'(LANE_COUNT));
			// drop positions past the beat, lanes past the fourth, unwritten slots
			keep_s1 <= ({1'b0, pos_q} < (PW+1)'(BEAT_LENGTH)) &&
				(slot_ext < (SW+3)'(LANE_COUNT)) &&
				(wrapped_q || (addr_q < ws_q));
			end_s1  <= slot_end;
			last_s1 <= word_last;
			word_s1 <= word_ext[5:0];
		end
	end

	// assemble the word lane by lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_full_s2 <= 1'b0;
		end else if (v_s1 && end_s1) begin
			asm_full_s2 <= 1'b1;
		end else if (xfer) begin
			asm_full_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			// samples past the fourth of a group have no lane: leave the lanes alone
			if (lane_ok_s1) begin
				if (keep_s1) begin
					asm_lane_s2[lane_s1] <= rdata_s1;
				end else begin
					asm_lane_s2[lane_s1] <= '0;
				end
			end
			if (end_s1) begin
				asm_word_s2 <= word_s1;
				asm_last_s2 <= last_s1;
			end
		end
	end

	// result register: assembled words, or a refusal beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer || refuse_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			out_peak_q   <= peak_q;
			out_word_q   <= asm_word_s2;
			out_lane_q   <= asm_lane_s2;
			out_status_q <= overrun_q ? STATUS_OVERRUN : STATUS_OK;
			out_last_q   <= asm_last_s2;
		end else if (refuse_load) begin
			out_peak_q   <= peak_q;
			out_word_q   <= '0;
			for (int i = 0; i < LANE_COUNT; i++) begin
				out_lane_q[i] <= '0;
			end
			out_status_q <= STATUS_REFUSED;
			out_last_q   <= 1'b1;
		end
	end

	// lanes beyond the samples per word carry zero
	always_comb begin
		result.valid            = out_valid_q;
		result.data.beat_peak   = out_peak_q;
		result.data.word_number = out_word_q;
		result.data.sample_a    = (SAMPLES_PER_WORD > 0) ? out_lane_q[0] : '0;
		result.data.sample_b    = (SAMPLES_PER_WORD > 1) ? out_lane_q[1] : '0;
		result.data.sample_c    = (SAMPLES_PER_WORD > 2) ? out_lane_q[2] : '0;
		result.data.sample_d    = (SAMPLES_PER_WORD > 3) ? out_lane_q[3] : '0;
		result.data.status      = out_status_q;
		result.data.last        = out_last_q;
	end

endmodule

`default_nettype wire

### test/beat_capture_checker.sv
`timescale 1ns / 1ps
// Window-capture predictor and result comparison for the beat window capture block.
module beat_capture_checker import bwc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	bwc_in_if           item,
	bwc_out_if          result,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	localparam int RING_DEPTH       = 1024;
	localparam int SLOT_BITS        = $clog2(RING_DEPTH);
	localparam int PRE_SAMPLES      = 72;
	localparam int POST_SAMPLES     = 71;
	localparam int BEAT_LENGTH      = 144;
	localparam int SAMPLES_PER_WORD = 4;
	localparam int WORD_COUNT = (BEAT_LENGTH + SAMPLES_PER_WORD - 1) / SAMPLES_PER_WORD;

	logic [WORD_WIDTH-1:0] ring [RING_DEPTH];
	logic [SLOT_BITS-1:0]  write_slot;
	logic [WORD_WIDTH-1:0] newest_index;
	logic                  armed;
	logic [WORD_WIDTH-1:0] armed_peak;
	out_item_t             words_due [$];

	// The window closes once the newest index lies strictly past its end.
	function automatic logic window_complete(input logic [WORD_WIDTH-1:0] peak);
		return {1'b0, newest_index} > {1'b0, peak} + 33'(POST_SAMPLES);
	endfunction

	task automatic queue_window(input logic [WORD_WIDTH-1:0] peak);
		logic [32:0]          span;
		logic [SLOT_BITS-1:0] start_slot;
		logic [1:0]           word_status;
		logic [WORD_WIDTH-1:0] lane [LANE_COUNT];
		out_item_t            word;
		int                   pos;
		span = {1'b0, newest_index} - ({1'b0, peak} - 33'(PRE_SAMPLES)) + 33'd1;
		word_status = (span > 33'(RING_DEPTH)) ? STATUS_OVERRUN : STATUS_OK;
		start_slot = write_slot - span[SLOT_BITS-1:0];
		for (int w = 0; w < WORD_COUNT; w++) begin
			for (int s = 0; s < LANE_COUNT; s++) begin
				pos = w * SAMPLES_PER_WORD + s;
				if (s < SAMPLES_PER_WORD && pos < BEAT_LENGTH)
					lane[s] = ring[SLOT_BITS'(start_slot + pos)];
				else
					lane[s] = '0;
			end
			word.beat_peak   = peak;
			word.word_number = 6'(w);
			word.sample_a    = lane[0];
			word.sample_b    = lane[1];
			word.sample_c    = lane[2];
			word.sample_d    = lane[3];
			word.status      = word_status;
			word.last        = (w == WORD_COUNT - 1);
			words_due.push_back(word);
		end
	endtask

	task automatic predict_capture(input in_item_t it);
		out_item_t refusal;
		if (it.cmd == CMD_PUSH) begin
			ring[write_slot] = it.push_value;
			newest_index = it.push_index;
			write_slot = write_slot + 1'b1;
			if (armed && window_complete(armed_peak)) begin
				armed = 1'b0;
				queue_window(armed_peak);
			end
		end else if (it.peak_index >= 32'(PRE_SAMPLES)) begin
			if (armed) begin
				refusal = '0;
				refusal.beat_peak = it.peak_index;
				refusal.status    = STATUS_REFUSED;
				refusal.last      = 1'b1;
				words_due.push_back(refusal);
			end else if (window_complete(it.peak_index)) begin
				queue_window(it.peak_index);
			end else begin
				armed = 1'b1;
				armed_peak = it.peak_index;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	task automatic compare_word(input out_item_t got);
		out_item_t want;
		if (words_due.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result word, expected none, got %h", $time, got);
			return;
		end
		want = words_due.pop_front();
		check_field("beat_peak", want.beat_peak, got.beat_peak);
		check_field("word_number", 32'(want.word_number), 32'(got.word_number));
		check_field("sample_a", want.sample_a, got.sample_a);
		check_field("sample_b", want.sample_b, got.sample_b);
		check_field("sample_c", want.sample_c, got.sample_c);
		check_field("sample_d", want.sample_d, got.sample_d);
		check_field("status", 32'(want.status), 32'(got.status));
		check_field("last", 32'(want.last), 32'(got.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++)
				ring[i] = '0;
			write_slot   = '0;
			newest_index = '0;
			armed        = 1'b0;
			armed_peak   = '0;
			words_due.delete();
			mismatches   = 0;
			outstanding  = 0;
		end else begin
			if (result.valid === 1'b1 && result.ready === 1'b1)
				compare_word(result.data);
			if (item.valid === 1'b1 && item.ready === 1'b1)
				predict_capture(item.data);
			outstanding = words_due.size();
		end
	end

endmodule

### test/beat_window_capture_test.sv
`timescale 1ns / 1ps
// Stimulus, handshake pacing and verdict for the beat window capture block.
module beat_window_capture_test;
	import bwc_pkg::*;

	localparam int          CLK_HALF    = 6;
	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          IDLE_PCT    = 21;
	localparam int          DRAIN_WAIT  = 300;
	localparam logic [31:0] MIN_PEAK    = 32'd72;
	localparam logic [31:0] TOP_INDEX   = 32'hffff_ffff;
	// Lowest peak whose window end reaches the top index: it can never close.
	localparam logic [31:0] STUCK_PEAK  = 32'hffff_ffb8;

	logic        clk;
	logic        arst_n;
	logic        no_idle;
	logic [31:0] next_index;
	int unsigned cycle_count = 0;
	int unsigned mismatches;
	int unsigned outstanding;

	bwc_in_if  item_ch ();
	bwc_out_if result_ch ();

	beat_window_capture dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	beat_capture_checker capture_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Guard against a hung handshake: give up well past the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: stall at random, except during the calm stretch.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Offer one beat from a falling edge and hold it until it is taken.
	// Valid stays high on return so that back-to-back beats never drop it;
	// whoever pauses the stream lowers it.
	task automatic send_beat(input logic cmd_v, input logic [31:0] idx,
			input logic [31:0] value, input logic [31:0] peak);
		in_item_t beat_data;
		beat_data.cmd        = cmd_v;
		beat_data.push_index = idx;
		beat_data.push_value = value;
		beat_data.peak_index = peak;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= beat_data;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Unused fields carry random junk: the block must ignore them.
	task automatic push(input logic [31:0] idx, input logic [31:0] value);
		send_beat(CMD_PUSH, idx, value, $urandom());
	endtask

	task automatic request(input logic [31:0] peak);
		send_beat(CMD_PEAK, $urandom(), $urandom(), peak);
	endtask

	// Drop valid and hold off until every predicted word has come out.
	task automatic settle();
		item_ch.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// Mostly a running stream of pushes with peaks placed around the newest
	// index, so that windows arm, close and read real data; the rest is noise.
	task automatic random_phase(input int n);
		int unsigned done_n;
		int unsigned roll;
		int unsigned back;
		logic [31:0] peak;
		done_n = 0;
		while (done_n < n) begin
			roll = $urandom_range(99);
			done_n++;
			if (roll < 70) begin
				push(next_index, $urandom());
				next_index++;
			end else if (roll < 80) begin
				// Peak a little ahead of or behind the stream: some close at
				// once, others stay armed until later pushes.
				back = $urandom_range(150);
				peak = (next_index + 30 > back) ? next_index + 30 - back : MIN_PEAK + back;
				request(peak);
			end else if (roll < 84) begin
				// Window start far behind the ring: stale data, overrun status.
				if (next_index > 1500)
					peak = next_index - 1024 - $urandom_range(400);
				else
					peak = MIN_PEAK + $urandom_range(50);
				request(peak);
			end else if (roll < 89) begin
				// Too low to capture: ignored, so not counted.
				done_n--;
				request($urandom_range(MIN_PEAK - 1));
			end else if (roll < 94) begin
				// Stray index anywhere in the range; the stream then carries on.
				push($urandom(), $urandom());
			end else begin
				// Gap in the running index.
				next_index += $urandom_range(1, 400);
				push(next_index, $urandom());
				next_index++;
			end
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		arst_n        = 1'b0;
		no_idle       = 1'b0;
		next_index    = 32'd1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: low peaks are ignored, the lowest valid peak arms.
		request(32'd0);
		request(MIN_PEAK - 1);
		request(MIN_PEAK);
		// Refuse a second peak while one is armed.
		request(32'd1000);
		// Window end reached exactly: not yet; one past it: capture.
		push(32'd143, 32'h7fff_ffff);
		push(32'd144, 32'h8000_0000);
		// Newest index near the top; peaks well behind close at once, overrun.
		push(TOP_INDEX - 1, 32'hffff_ffff);
		request(32'haaaa_aaaa);
		request(32'h5555_5555);
		push(TOP_INDEX, 32'h0000_0000);
		push(32'd0, 32'h5a5a_5a5a);

		random_phase(185);
		// Pause the sender until everything predicted has drained.
		settle();
		no_idle <= 1'b1;
		random_phase(75);
		no_idle <= 1'b0;
		random_phase(120);
		settle();

		// Close anything armed, then arm a peak that can never close:
		// later peaks are refused and pushes emit nothing.
		push(TOP_INDEX, $urandom());
		settle();
		request(STUCK_PEAK);
		request(TOP_INDEX);
		push(TOP_INDEX, $urandom());
		request(MIN_PEAK);

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
